// File: rtl/assert_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KFU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define KFU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/kfu_pkg.sv
// Shared constants of the Kuwahara filter unit.
package kfu_pkg;
    localparam int PIX_W      = 8;
    localparam int DIM_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int N_MIN      = 2;
    localparam int N_HI       = 8;
    localparam int DIM_MIN    = 17;
    localparam int DIM_MAX    = 1024;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_REGION_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;
endpackage

// File: rtl/kfu_ram.sv
// Generic simple dual-port RAM with registered read.
module kfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: rtl/kuwahara_filter_unit.sv
// Kuwahara filter unit: line store, window scan, variance compare, mean divide.
//
//   channel  | dir | handshake               | payload
//   ---------+-----+-------------------------+-----------------------------------
//   input    | in  | i_in_valid / o_in_stall | i_op, i_pixel
//   result   | out | o_res_valid/i_res_stall | o_out_pixel, o_out_valid, o_out_last
//   config   | in  | i_cfg_we                | i_cfg_index, i_cfg_data
//
// One item at a time. An item with no output due goes straight to the final
// state; a border pixel passes its stored value through; an interior pixel's
// (2n-1)^2 window is scanned from the line store's single read port, one pixel per cycle.
// Synchronous active-low reset clears counters, FSM and the result valid flag;
// the line store is not cleared. A stalled result holds the FSM in its final
// state; a new item may be taken while the previous result waits.
module kuwahara_filter_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_KERNEL = 15
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_op,
    input  logic [kfu_pkg::PIX_W-1:0]      i_pixel,
    output logic                           o_res_valid,
    input  logic                           i_res_stall,
    output logic [kfu_pkg::PIX_W-1:0]      o_out_pixel,
    output logic                           o_out_valid,
    output logic                           o_out_last,
    input  logic                           i_cfg_we,
    input  logic [kfu_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [kfu_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    localparam int DEPTH = MAX_KERNEL * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int SLW   = $clog2(MAX_KERNEL);
    localparam int WMAX  = (MAX_WIDTH < kfu_pkg::DIM_MAX) ? MAX_WIDTH : kfu_pkg::DIM_MAX;
    localparam int NTOP  = ((MAX_KERNEL + 1) / 2 < kfu_pkg::N_HI) ?
                           (MAX_KERNEL + 1) / 2 : kfu_pkg::N_HI;
    localparam int DW    = kfu_pkg::DIM_W;
    localparam int PW    = kfu_pkg::PIX_W;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DRAIN, S_VAR, S_DIV, S_FIN} t_state;

    t_state          r_state;
    logic [3:0]      r_n;
    logic [DW-1:0]   r_w, r_h;
    logic [DW-1:0]   r_col, r_row, r_oh, r_ow;
    logic [SLW-1:0]  r_slot, r_oslot, r_rslot;
    logic [20:0]     r_cnt, r_opos;
    logic            r_emit, r_border, r_last;
    logic [DW-1:0]   r_bcol;
    logic [3:0]      r_wsz, r_sr, r_sc;
    logic            r_rdv;
    logic [3:0]      r_qf;
    logic [13:0]     r_sum [4];
    logic [21:0]     r_sq  [4];
    logic [1:0]      r_k;
    logic            r_ph;
    logic [28:0]     r_p1, r_best;
    logic [27:0]     r_p2;
    logic [13:0]     r_bsum, r_rem;
    logic [2:0]      r_di;
    logic [PW-1:0]   r_res;
    logic            r_ov, r_ovld, r_olast;
    logic [PW-1:0]   r_opix;

    logic [DW-1:0]   n_col, n_row, n_oh, n_ow;
    logic [SLW-1:0]  n_slot, n_oslot;
    logic [20:0]     n_cnt, n_opos;

    logic            acc, wr_en, done_n, emit, border, out_free;
    logic [3:0]      n1;
    logic [21:0]     tot_p;
    logic [20:0]     total;
    logic [15:0]     lat;
    logic [DW-1:0]   w1;
    logic [7:0]      nsq;
    logic [SLW:0]    sb;
    logic [AW-1:0]   waddr, raddr;
    logic [PW-1:0]   rdata;
    logic [28:0]     var_c;
    logic [13:0]     dsh;
    logic [3:0]      cn;
    logic [DW-1:0]   cw, ch;

    assign acc        = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_ov || !i_res_stall;
    assign n1         = r_n - 4'd1;
    assign tot_p      = {11'b0, r_w} * {11'b0, r_h};
    assign total      = tot_p[20:0];
    assign w1         = r_w + 11'd1;
    assign lat        = {12'b0, n1} * {5'b0, w1};
    assign nsq        = {4'b0, r_n} * {4'b0, r_n};
    assign var_c      = r_p1 - {1'b0, r_p2};
    assign dsh        = 14'({6'b0, nsq} << r_di);

    assign waddr = AW'(r_slot * MAX_WIDTH + r_col);
    assign raddr = AW'(r_rslot * MAX_WIDTH + r_bcol + r_sc);

    assign border = (r_oh < {7'b0, r_n}) || (r_oh >= r_h - {7'b0, r_n}) ||
                    (r_ow < {7'b0, r_n}) || (r_ow >= r_w - {7'b0, r_n});

    // Counter updates for the item being accepted.
    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_slot  = r_slot;
        n_cnt   = r_cnt;
        n_opos  = r_opos;
        n_oh    = r_oh;
        n_ow    = r_ow;
        n_oslot = r_oslot;
        wr_en   = acc && (i_op == kfu_pkg::OP_PIXEL) && (r_row < r_h);
        if (wr_en) begin
            n_cnt = r_cnt + 21'd1;
            if (r_col + 11'd1 >= r_w) begin
                n_col  = '0;
                n_row  = r_row + 11'd1;
                n_slot = (r_slot == SLW'(MAX_KERNEL - 1)) ? '0 : r_slot + 1'b1;
            end else begin
                n_col = r_col + 11'd1;
            end
        end
        done_n = (n_row >= r_h);
        emit   = (r_opos < total) && (done_n || (r_opos + 21'(lat) < n_cnt));
        if (emit) begin
            if (r_opos == total - 21'd1) begin
                n_col   = '0;
                n_row   = '0;
                n_slot  = '0;
                n_cnt   = '0;
                n_opos  = '0;
                n_oh    = '0;
                n_ow    = '0;
                n_oslot = '0;
            end else begin
                n_opos = r_opos + 21'd1;
                if (r_ow + 11'd1 >= r_w) begin
                    n_ow    = '0;
                    n_oh    = r_oh + 11'd1;
                    n_oslot = (r_oslot == SLW'(MAX_KERNEL - 1)) ? '0 : r_oslot + 1'b1;
                end else begin
                    n_ow = r_ow + 11'd1;
                end
            end
        end
        sb = {1'b0, r_oslot} + (SLW+1)'(MAX_KERNEL) - (SLW+1)'(n1);
        if (sb >= (SLW+1)'(MAX_KERNEL)) begin
            sb = sb - (SLW+1)'(MAX_KERNEL);
        end
        // Clamp the incoming register value.
        cn = i_cfg_data[3:0];
        if (cn < 4'(kfu_pkg::N_MIN)) cn = 4'(kfu_pkg::N_MIN);
        if (cn > 4'(NTOP)) cn = 4'(NTOP);
        cw = i_cfg_data;
        if (cw < DW'(kfu_pkg::DIM_MIN)) cw = DW'(kfu_pkg::DIM_MIN);
        if (cw > DW'(WMAX)) cw = DW'(WMAX);
        ch = i_cfg_data;
        if (ch < DW'(kfu_pkg::DIM_MIN)) ch = DW'(kfu_pkg::DIM_MIN);
        if (ch > DW'(kfu_pkg::DIM_MAX)) ch = DW'(kfu_pkg::DIM_MAX);
    end

    kfu_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_line_store (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(waddr),
        .i_wdata(i_pixel),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // Quadrant statistics from the scan.
    always_ff @(posedge i_clk) begin
        if (acc) begin
            for (int k = 0; k < 4; k++) begin
                r_sum[k] <= '0;
                r_sq[k]  <= '0;
            end
        end else if (r_rdv) begin
            for (int k = 0; k < 4; k++) begin
                if (r_qf[k]) begin
                    r_sum[k] <= r_sum[k] + {6'b0, rdata};
                    r_sq[k]  <= r_sq[k] + {6'b0, 16'(rdata) * 16'(rdata)};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_n     <= 4'd4;
            r_w     <= 11'd512;
            r_h     <= 11'd512;
            r_col   <= '0;
            r_row   <= '0;
            r_slot  <= '0;
            r_cnt   <= '0;
            r_opos  <= '0;
            r_oh    <= '0;
            r_ow    <= '0;
            r_oslot <= '0;
            r_rdv   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_rdv <= 1'b0;
            if (r_ov && !i_res_stall) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_we && (i_cfg_index == kfu_pkg::CFG_REGION_SIZE ||
                             i_cfg_index == kfu_pkg::CFG_IMAGE_WIDTH ||
                             i_cfg_index == kfu_pkg::CFG_IMAGE_HEIGHT)) begin
                case (i_cfg_index)
                    kfu_pkg::CFG_REGION_SIZE:  r_n <= cn;
                    kfu_pkg::CFG_IMAGE_WIDTH:  r_w <= cw;
                    kfu_pkg::CFG_IMAGE_HEIGHT: r_h <= ch;
                    default: ;
                endcase
                r_col   <= '0;
                r_row   <= '0;
                r_slot  <= '0;
                r_cnt   <= '0;
                r_opos  <= '0;
                r_oh    <= '0;
                r_ow    <= '0;
                r_oslot <= '0;
            end
            case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_col    <= n_col;
                        r_row    <= n_row;
                        r_slot   <= n_slot;
                        r_cnt    <= n_cnt;
                        r_opos   <= n_opos;
                        r_oh     <= n_oh;
                        r_ow     <= n_ow;
                        r_oslot  <= n_oslot;
                        r_emit   <= emit;
                        r_border <= border;
                        r_last   <= emit && (r_opos == total - 21'd1);
                        r_res    <= '0;
                        r_sr     <= '0;
                        r_sc     <= '0;
                        if (border) begin
                            r_rslot <= r_oslot;
                            r_bcol  <= r_ow;
                            r_wsz   <= 4'd1;
                        end else begin
                            r_rslot <= sb[SLW-1:0];
                            r_bcol  <= r_ow - {7'b0, n1};
                            r_wsz   <= 4'({r_n, 1'b0} - 5'd1);
                        end
                        r_state <= emit ? S_SCAN : S_FIN;
                    end
                end
                S_SCAN: begin
                    r_rdv <= 1'b1;
                    r_qf  <= {(r_sr >= n1) && (r_sc >= n1), (r_sr >= n1) && (r_sc <= n1),
                              (r_sr <= n1) && (r_sc >= n1), (r_sr <= n1) && (r_sc <= n1)};
                    if (r_sc == r_wsz - 4'd1) begin
                        r_sc    <= '0;
                        r_sr    <= r_sr + 4'd1;
                        r_rslot <= (r_rslot == SLW'(MAX_KERNEL - 1)) ? '0 : r_rslot + 1'b1;
                        if (r_sr == r_wsz - 4'd1) begin
                            r_state <= S_DRAIN;
                        end
                    end else begin
                        r_sc <= r_sc + 4'd1;
                    end
                end
                S_DRAIN: begin
                    // a border pixel passes through; the divider builds the mean from zero
                    r_res <= r_border ? rdata : '0;
                    r_k   <= '0;
                    r_ph  <= 1'b0;
                    r_state <= r_border ? S_FIN : S_VAR;
                end
                S_VAR: begin
                    if (!r_ph) begin
                        r_p1 <= {7'b0, nsq[6:0]} * {7'b0, r_sq[r_k]};
                        r_p2 <= {14'b0, r_sum[r_k]} * {14'b0, r_sum[r_k]};
                        r_ph <= 1'b1;
                    end else begin
                        r_ph <= 1'b0;
                        // keep the earlier quadrant on a tie
                        if (r_k == 2'd0 || var_c < r_best) begin
                            r_best <= var_c;
                            r_bsum <= r_sum[r_k];
                            if (r_k == 2'd3) r_rem <= r_sum[r_k];
                        end else if (r_k == 2'd3) begin
                            r_rem <= r_bsum;
                        end
                        r_k <= r_k + 2'd1;
                        if (r_k == 2'd3) begin
                            r_di    <= 3'd7;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (r_rem >= dsh) begin
                        r_rem        <= r_rem - dsh;
                        r_res[r_di]  <= 1'b1;
                    end
                    if (r_di == 3'd0) begin
                        r_state <= S_FIN;
                    end
                    r_di <= r_di - 3'd1;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_ov    <= 1'b1;
                        r_opix  <= r_emit ? r_res : '0;
                        r_ovld  <= r_emit;
                        r_olast <= r_last;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res_valid = r_ov;
    assign o_out_pixel = r_opix;
    assign o_out_valid = r_ovld;
    assign o_out_last  = r_olast;
endmodule

// File: rtl/kfu_checker.sv
// Port-level checker for the Kuwahara filter unit and its bind.
`include "assert_macros.svh"

module kfu_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic                           o_res_valid,
    input logic                           i_res_stall,
    input logic [kfu_pkg::PIX_W-1:0]      o_out_pixel,
    input logic                           o_out_valid,
    input logic                           o_out_last
);
    `KFU_ASSERT_NXT(a_res_hold, i_clk, i_rst_n, o_res_valid && i_res_stall, o_res_valid && $stable(o_out_pixel) && $stable(o_out_valid) && $stable(o_out_last))
    `KFU_ASSERT_IMP(a_last_valid, i_clk, i_rst_n, o_res_valid && o_out_last, o_out_valid)
    `KFU_ASSERT_IMP(a_empty_zero, i_clk, i_rst_n, o_res_valid && !o_out_valid, o_out_pixel == '0)
    `KFU_ASSERT_NXT(a_one_item, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
endmodule

bind kuwahara_filter_unit kfu_checker u_kfu_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .o_res_valid(o_res_valid),
    .i_res_stall(i_res_stall),
    .o_out_pixel(o_out_pixel),
    .o_out_valid(o_out_valid),
    .o_out_last (o_out_last)
);
